// ----- design/srd_pkg.sv -----
package srd_pkg;

   // Record framing
   localparam int unsigned HDR_BYTES            = 48;
   localparam int unsigned TRL_BYTES            = 4;
   localparam int unsigned HDR_BITS             = HDR_BYTES * 8;
   localparam int unsigned MAX_RECORD_BYTES_DEF = 256 * 1024 * 1024;
   // "SPSREC\r\n" as it lands in the little-endian header word
   localparam logic [63:0] REC_MAGIC            = 64'h0A0D_4345_5253_5053;
   localparam logic [31:0] CRC_POLY             = 32'h82F6_3B78;

   // Field widths
   localparam int unsigned PPS_W   = 27;
   localparam int unsigned RAW_W   = 16;
   localparam int unsigned POW_W   = 57;
   localparam int unsigned CODE_W  = 4;
   localparam int unsigned REQ_W   = 8;
   localparam int unsigned RSP_W   = 272;
   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned CSR_W   = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_POINTS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DENOM  = 4'd3;

   // Input kinds
   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_END  = 1'b1;

   // Result kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [CODE_W-1:0] {
      ST_OK        = 4'd0,
      ST_MAGIC     = 4'd1,
      ST_HDRLEN    = 4'd2,
      ST_FLAGS     = 4'd3,
      ST_RECLEN    = 4'd4,
      ST_SEQ       = 4'd5,
      ST_DURATION  = 4'd6,
      ST_COUNT     = 4'd7,
      ST_PAYLOAD   = 4'd8,
      ST_TOTAL     = 4'd9,
      ST_CRC       = 4'd10,
      ST_TRUNCATED = 4'd11,
      ST_CLEAN_END = 4'd12
   } status_type;

   // CRC-32C, reflected, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- design/sweep_record_deframer_top.sv -----
// Header bytes and trailer bytes are taken from the input in the idle state; the last
// header byte starts the header checks (one check per cycle), and a failing check issues a status result.
// A sample's high byte starts the multiply, prepare, 58-bit quotient division on the
// shared 2-bit-per-cycle divider, sign fix and output steps, in that order.
// One transaction is in flight at a time; the output register frees the input.
// Synchronous active-high reset returns to the header phase with config at default.
module sweep_record_deframer_top #(
   parameter int unsigned MAX_RECORD_BYTES = srd_pkg::MAX_RECORD_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [srd_pkg::REQ_W-1:0]       req_tdata,  // data_byte
   input  logic                            req_tuser,  // mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // sample raw, power, status code, record sequence, start stamp,
   // end stamp, zero fill
   output logic [srd_pkg::RSP_W-1:0]       rsp_tdata,
   output logic                            rsp_tuser,  // kind
   output logic                            rsp_tlast,  // last_of_record
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [srd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srd_pkg::CSR_W-1:0]       csr_data
);
   import srd_pkg::*;

   localparam int unsigned IDX_W     = $clog2(MAX_RECORD_BYTES);
   localparam int unsigned DIV_W     = 58;
   localparam int unsigned DIV_STEPS = DIV_W / 2;
   localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);
   localparam int unsigned NUM_W     = 50;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_MUL, S_PREP, S_DIV, S_FIX, S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_HEADER, PH_PAYLOAD, PH_TRAILER
   } phase_type;

   // Sequencer and record state
   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic               halted_ff, halted_in;
   logic               hvalid_ff, hvalid_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   paylen_ff, paylen_in;
   logic [HDR_BITS-1:0] hdr_ff, hdr_in;
   logic [63:0]        seq_exp_ff, seq_exp_in;
   logic [31:0]        crc_ff, crc_in;
   logic [7:0]         low_ff, low_in;
   logic [31:0]        trl_ff, trl_in;
   logic [3:0]         step_ff, step_in;

   // Calibration datapath
   logic [RAW_W-1:0]   raw_ff, raw_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic               neg_ff, neg_in;
   logic [DIV_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [31:0]        rem_ff, rem_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;

   // Pending result
   logic               p_kind_ff, p_kind_in;
   logic [RAW_W-1:0]   p_raw_ff, p_raw_in;
   logic [POW_W-1:0]   p_pow_ff, p_pow_in;
   status_type         p_code_ff, p_code_in;
   logic [63:0]        p_seq_ff, p_seq_in;
   logic [63:0]        p_st_ff, p_st_in;
   logic [63:0]        p_en_ff, p_en_in;

   // Output register
   logic               o_valid_ff, o_valid_in;
   logic               o_kind_ff, o_kind_in;
   logic [RSP_W-1:0]   o_data_ff, o_data_in;

   // Configuration
   logic [PPS_W-1:0]   pps_ff, pps_in;
   logic signed [31:0] scale_ff, scale_in;
   logic signed [31:0] offs_ff, offs_in;
   logic [31:0]        den_ff, den_in;

   // Header fields
   logic [63:0] h_magic, h_seq, h_st, h_en;
   logic [15:0] h_hlen, h_flags;
   logic [31:0] h_rec, h_cnt, h_pay;

   assign h_magic = hdr_ff[63:0];
   assign h_rec   = hdr_ff[95:64];
   assign h_hlen  = hdr_ff[111:96];
   assign h_flags = hdr_ff[127:112];
   assign h_seq   = hdr_ff[191:128];
   assign h_st    = hdr_ff[255:192];
   assign h_en    = hdr_ff[319:256];
   assign h_cnt   = hdr_ff[351:320];
   assign h_pay   = hdr_ff[383:352];

   // Misc combinational helpers
   logic               take, out_free, chk_fail;
   logic [7:0]         b;
   logic [IDX_W-1:0]   idx_nx;
   logic [31:0]        crc_nx, trl_nx;
   logic signed [48:0] prod;
   logic [NUM_W-1:0]   mag;
   logic [32:0]        r1, r2, dv;
   logic               ge1, ge2;
   logic [31:0]        rm1, rm2;
   logic [DIV_W-1:0]   q_neg;
   logic [63:0]        i_seq, i_st, i_en;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign take       = req_tvalid && req_tready;
   assign out_free   = !o_valid_ff || rsp_tready;
   assign b          = req_tdata;
   assign idx_nx     = idx_ff + IDX_W'(1);
   assign crc_nx     = crc_byte(crc_ff, b);
   assign trl_nx     = trl_ff | ({24'd0, b} << {idx_ff[1:0], 3'b000});

   // Header info for a status issued now
   assign i_seq = hvalid_ff ? h_seq : seq_exp_ff;
   assign i_st  = hvalid_ff ? h_st  : 64'd0;
   assign i_en  = hvalid_ff ? h_en  : 64'd0;

   // Shared multiply, magnitude and two divider steps
   assign prod = $signed({1'b0, raw_ff}) * scale_ff;
   assign mag  = num_ff[NUM_W-1] ? (~num_ff + NUM_W'(1)) : num_ff;
   assign dv   = {1'b0, den_ff};
   assign r1   = {rem_ff, dvd_ff[DIV_W-1]};
   assign ge1  = (r1 >= dv);
   assign rm1  = ge1 ? 32'(r1 - dv) : r1[31:0];
   assign r2   = {rm1, dvd_ff[DIV_W-2]};
   assign ge2  = (r2 >= dv);
   assign rm2  = ge2 ? 32'(r2 - dv) : r2[31:0];
   assign q_neg = ~quo_ff + DIV_W'(1);

   // One header check per step, in status-code order
   always_comb begin
      chk_fail = 1'b0;
      case (step_ff)
         4'd0: chk_fail = (h_magic != REC_MAGIC);
         4'd1: chk_fail = (h_hlen != 16'(HDR_BYTES));
         4'd2: chk_fail = (h_flags != 16'd0);
         4'd3: chk_fail = (h_rec < 32'(HDR_BYTES + TRL_BYTES))
                       || (h_rec > 32'(MAX_RECORD_BYTES));
         4'd4: chk_fail = (h_seq != seq_exp_ff);
         4'd5: chk_fail = ($signed(h_en) < $signed(h_st));
         4'd6: chk_fail = (h_cnt != {{(32-PPS_W){1'b0}}, pps_ff});
         4'd7: chk_fail = h_cnt[31] || (h_pay != {h_cnt[30:0], 1'b0});
         4'd8: chk_fail = ({1'b0, h_rec} != ({1'b0, h_pay} + 33'(HDR_BYTES + TRL_BYTES)));
         default: chk_fail = 1'b0;
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      halted_in  = halted_ff;
      hvalid_in  = hvalid_ff;
      idx_in     = idx_ff;
      paylen_in  = paylen_ff;
      hdr_in     = hdr_ff;
      seq_exp_in = seq_exp_ff;
      crc_in     = crc_ff;
      low_in     = low_ff;
      trl_in     = trl_ff;
      step_in    = step_ff;
      raw_in     = raw_ff;
      num_in     = num_ff;
      neg_in     = neg_ff;
      dvd_in     = dvd_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      dcnt_in    = dcnt_ff;
      p_kind_in  = p_kind_ff;
      p_raw_in   = p_raw_ff;
      p_pow_in   = p_pow_ff;
      p_code_in  = p_code_ff;
      p_seq_in   = p_seq_ff;
      p_st_in    = p_st_ff;
      p_en_in    = p_en_ff;
      o_valid_in = o_valid_ff && !rsp_tready;
      o_kind_in  = o_kind_ff;
      o_data_in  = o_data_ff;
      pps_in     = pps_ff;
      scale_in   = scale_ff;
      offs_in    = offs_ff;
      den_in     = den_ff;

      // Register writes
      if (csr_valid) begin
         unique case (csr_index)
            REG_POINTS: pps_in   = csr_data[PPS_W-1:0];
            REG_SCALE:  scale_in = csr_data;
            REG_OFFSET: offs_in  = csr_data;
            REG_DENOM:  den_in   = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (take && !halted_ff) begin
               // status defaults for this transaction
               p_kind_in = KIND_STATUS;
               p_raw_in  = '0;
               p_pow_in  = '0;
               p_seq_in  = i_seq;
               p_st_in   = i_st;
               p_en_in   = i_en;
               if (req_tuser == MODE_END) begin
                  p_code_in = (phase_ff == PH_HEADER && idx_ff == '0) ? ST_CLEAN_END
                                                                       : ST_TRUNCATED;
                  halted_in = 1'b1;
                  state_in  = S_EMIT;
               end else begin
                  unique case (phase_ff)
                     PH_HEADER: begin
                        hdr_in = {b, hdr_ff[HDR_BITS-1:8]};
                        crc_in = crc_nx;
                        idx_in = idx_nx;
                        if (idx_nx == IDX_W'(HDR_BYTES)) begin
                           hvalid_in = 1'b1;
                           step_in   = '0;
                           state_in  = S_CHECK;
                        end
                     end
                     PH_PAYLOAD: begin
                        crc_in = crc_nx;
                        idx_in = idx_nx;
                        if (idx_nx >= paylen_ff) begin
                           idx_in   = '0;
                           phase_in = PH_TRAILER;
                        end
                        if (!idx_ff[0]) begin
                           low_in = b;
                        end else begin
                           raw_in   = {b, low_ff};
                           state_in = S_MUL;
                        end
                     end
                     PH_TRAILER: begin
                        trl_in = trl_nx;
                        idx_in = idx_nx;
                        if (idx_nx == IDX_W'(TRL_BYTES)) begin
                           state_in = S_EMIT;
                           if (trl_nx != ~crc_ff) begin
                              p_code_in = ST_CRC;
                              halted_in = 1'b1;
                           end else begin
                              p_code_in  = ST_OK;
                              seq_exp_in = seq_exp_ff + 64'd1;
                              phase_in   = PH_HEADER;
                              idx_in     = '0;
                              crc_in     = '1;
                              trl_in     = '0;
                              paylen_in  = '0;
                              low_in     = '0;
                              hvalid_in  = 1'b0;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_CHECK: begin
            if (chk_fail) begin
               // a rejected header reports its own fields
               p_code_in = status_type'(step_ff + 4'd1);
               p_seq_in  = h_seq;
               p_st_in   = h_st;
               p_en_in   = h_en;
               halted_in = 1'b1;
               state_in  = S_EMIT;
            end else if (step_ff == 4'd8) begin
               paylen_in = h_pay[IDX_W-1:0];
               idx_in    = '0;
               trl_in    = '0;
               phase_in  = (h_pay == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
               state_in  = S_IDLE;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_MUL: begin
            num_in   = {prod[48], prod} + {{(NUM_W-32){offs_ff[31]}}, offs_ff};
            state_in = S_PREP;
         end
         S_PREP: begin
            neg_in   = num_ff[NUM_W-1];
            dvd_in   = {mag, 8'd0};
            quo_in   = '0;
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = rm2;
            quo_in  = {quo_ff[DIV_W-3:0], ge1, ge2};
            dvd_in  = {dvd_ff[DIV_W-3:0], 2'b00};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            p_kind_in = KIND_SAMPLE;
            p_raw_in  = raw_ff;
            p_code_in = ST_OK;
            p_seq_in  = h_seq;
            p_st_in   = h_st;
            p_en_in   = h_en;
            if (den_ff == 32'd0) begin
               p_pow_in = '0;
            end else begin
               p_pow_in = neg_ff ? q_neg[POW_W-1:0] : quo_ff[POW_W-1:0];
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               o_valid_in = 1'b1;
               o_kind_in  = p_kind_ff;
               o_data_in  = {3'b000, p_en_ff, p_st_ff, p_seq_ff, p_code_ff, p_pow_ff, p_raw_ff};
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_HEADER;
         halted_ff  <= 1'b0;
         hvalid_ff  <= 1'b0;
         idx_ff     <= '0;
         paylen_ff  <= '0;
         seq_exp_ff <= '0;
         crc_ff     <= '1;
         low_ff     <= '0;
         trl_ff     <= '0;
         step_ff    <= '0;
         dcnt_ff    <= '0;
         o_valid_ff <= 1'b0;
         pps_ff     <= PPS_W'(1);
         scale_ff   <= 32'sd1;
         offs_ff    <= 32'sd0;
         den_ff     <= 32'd1;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         halted_ff  <= halted_in;
         hvalid_ff  <= hvalid_in;
         idx_ff     <= idx_in;
         paylen_ff  <= paylen_in;
         seq_exp_ff <= seq_exp_in;
         crc_ff     <= crc_in;
         low_ff     <= low_in;
         trl_ff     <= trl_in;
         step_ff    <= step_in;
         dcnt_ff    <= dcnt_in;
         o_valid_ff <= o_valid_in;
         pps_ff     <= pps_in;
         scale_ff   <= scale_in;
         offs_ff    <= offs_in;
         den_ff     <= den_in;
      end
      hdr_ff    <= hdr_in;
      raw_ff    <= raw_in;
      num_ff    <= num_in;
      neg_ff    <= neg_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      p_kind_ff <= p_kind_in;
      p_raw_ff  <= p_raw_in;
      p_pow_ff  <= p_pow_in;
      p_code_ff <= p_code_in;
      p_seq_ff  <= p_seq_in;
      p_st_ff   <= p_st_in;
      p_en_ff   <= p_en_in;
      o_kind_ff <= o_kind_in;
      o_data_ff <= o_data_in;
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_kind_ff;
   assign rsp_tdata  = o_data_ff;

   // Halt is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff) else $error("halt released");

   // A failing status always leaves the block halted
   a_fail_halts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && p_kind_ff == KIND_STATUS && p_code_ff != ST_OK)
      |-> halted_ff) else $error("failing status without halt");

   // Outside the header phase a full header is held
   a_hvalid: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HEADER) |-> hvalid_ff) else $error("header not valid");

   // Divider count stays within its pass
   a_dcnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dcnt_ff < DCNT_W'(DIV_STEPS))) else $error("divider overrun");

   // Sample results carry no status and no end mark
   a_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_SAMPLE) |-> (rsp_tdata[76:73] == ST_OK))
      else $error("sample with status");

endmodule
